FILE: rtl/utf8cjk_pkg.sv
package utf8cjk_pkg;

   localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
   localparam logic [20:0] SPACE       = 21'h000020;
   localparam logic [5:0]  CONT_MASK   = 6'h3F;

   // Ideograph block bounds, low and high, inclusive
   localparam logic [20:0] IDEO_A_LO = 21'h004E00;
   localparam logic [20:0] IDEO_A_HI = 21'h009FFF;
   localparam logic [20:0] IDEO_B_LO = 21'h003400;
   localparam logic [20:0] IDEO_B_HI = 21'h004DBF;
   localparam logic [20:0] IDEO_C_LO = 21'h020000;
   localparam logic [20:0] IDEO_C_HI = 21'h02A6DF;
   localparam logic [20:0] IDEO_D_LO = 21'h02A700;
   localparam logic [20:0] IDEO_D_HI = 21'h02B73F;
   localparam logic [20:0] IDEO_E_LO = 21'h02B740;
   localparam logic [20:0] IDEO_E_HI = 21'h02B81F;
   localparam logic [20:0] IDEO_F_LO = 21'h02B920;
   localparam logic [20:0] IDEO_F_HI = 21'h02CEAF;
   localparam logic [20:0] IDEO_G_LO = 21'h00F900;
   localparam logic [20:0] IDEO_G_HI = 21'h00FAFF;
   localparam logic [20:0] IDEO_H_LO = 21'h02F800;
   localparam logic [20:0] IDEO_H_HI = 21'h02FA1F;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       string_last;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        align_change;
      logic        run_last;
      logic        string_end;
   } rsp_type;

   typedef struct packed {
      logic [20:0] cp;
      logic [2:0]  used;
   } dec_type;

   // State update and result count from the decoder
   typedef struct packed {
      logic       held_we;
      logic [1:0] held_idx;
      logic [1:0] held_count;
      logic [2:0] sequence_length;
      logic [1:0] res_count;
   } upd_type;

   typedef struct packed {
      logic empty;
      logic last_pop;
   } q_status_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   function automatic logic is_ideo(input logic [20:0] cp);
      return (cp >= IDEO_A_LO && cp <= IDEO_A_HI) ||
             (cp >= IDEO_B_LO && cp <= IDEO_B_HI) ||
             (cp >= IDEO_C_LO && cp <= IDEO_C_HI) ||
             (cp >= IDEO_D_LO && cp <= IDEO_D_HI) ||
             (cp >= IDEO_E_LO && cp <= IDEO_E_HI) ||
             (cp >= IDEO_F_LO && cp <= IDEO_F_HI) ||
             (cp >= IDEO_G_LO && cp <= IDEO_G_HI) ||
             (cp >= IDEO_H_LO && cp <= IDEO_H_HI);
   endfunction

   // Decode one code point from a four-byte window, lead first
   function automatic dec_type decode_one(input logic [3:0][7:0] w, input logic [2:0] avail);
      dec_type    d;
      logic [2:0] len;
      len    = lead_len(w[0]);
      d.used = 3'd1;
      d.cp   = REPLACEMENT;
      if (len == 3'd1) begin
         d.cp = {13'd0, w[0]};
      end else if (len != 3'd0 && avail >= len) begin
         d.used = len;
         case (len)
            3'd2: d.cp = {10'd0, w[0][4:0], w[1][5:0] & CONT_MASK};
            3'd3: d.cp = {5'd0, w[0][3:0], w[1][5:0] & CONT_MASK, w[2][5:0] & CONT_MASK};
            default: d.cp = {w[0][2:0], w[1][5:0] & CONT_MASK, w[2][5:0] & CONT_MASK,
                             w[3][5:0] & CONT_MASK};
         endcase
      end
      return d;
   endfunction

endpackage

FILE: rtl/utf8_decode_cjk_spacing_top.sv
// Channel   Ports                               Direction  Carries
// request   req_valid, req_ready, req_data      in         one byte, last-of-string flag
// response  rsp_valid, rsp_ready, rsp_data      out        code point, align, run/string end
// csr       csr_write_enable, csr_write_data    in         enable_cjk_spacing
//
// A request waits in the input register, then is decoded against the held sequence
// bytes, and its zero to three responses load a three-entry queue.
// One request per cycle while rsp_ready is high and a byte gives at most one response;
// a byte that gives more holds the queue until the single response port takes them all.
// Synchronous active-high reset clears control state and sets spacing on.
// Either side may stall at any time; nothing is dropped or repeated.
module utf8_decode_cjk_spacing_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  utf8cjk_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output utf8cjk_pkg::rsp_type  rsp_data,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   // input register
   logic                       in_valid_ff;
   logic                       in_valid_in;
   utf8cjk_pkg::req_type       in_data_ff;

   // decoder state: held bytes have no reset, only entries below the count are read
   logic [2:0][7:0]            held_ff;
   logic [1:0]                 held_count_ff;
   logic [2:0]                 seq_len_ff;
   logic                       enable_ff;

   utf8cjk_pkg::upd_type       upd;
   utf8cjk_pkg::rsp_type [2:0] res;
   utf8cjk_pkg::q_status_type  q_status;
   logic                       load;
   logic                       req_take;

   // advance the held request only when the queue frees up this cycle
   assign load      = in_valid_ff && (q_status.empty || q_status.last_pop);
   assign req_ready = !in_valid_ff || load;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (load && upd.held_we) begin
         held_ff[upd.held_idx] <= in_data_ff.byte_value;
      end
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_count_ff <= 2'd0;
         seq_len_ff    <= 3'd0;
         enable_ff     <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (load) begin
            held_count_ff <= upd.held_count;
            seq_len_ff    <= upd.sequence_length;
         end
         if (csr_write_enable) begin
            enable_ff <= csr_write_data;
         end
      end
   end

   utf8cjk_decode u_decode (
      .in_data         (in_data_ff),
      .held            (held_ff),
      .held_count      (held_count_ff),
      .sequence_length (seq_len_ff),
      .enable          (enable_ff),
      .upd             (upd),
      .res             (res)
   );

   utf8cjk_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_count (upd.res_count),
      .load_data  (res),
      .status     (q_status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: rtl/utf8cjk_decode.sv
module utf8cjk_decode (
   input  utf8cjk_pkg::req_type        in_data,
   input  logic [2:0][7:0]             held,
   input  logic [1:0]                  held_count,
   input  logic [2:0]                  sequence_length,
   input  logic                        enable,
   output utf8cjk_pkg::upd_type        upd,
   output utf8cjk_pkg::rsp_type [2:0]  res
);

   logic [3:0][7:0]             buf_b;
   logic [3:0][3:0][7:0]        win;
   logic [3:0][2:0]             avail;
   utf8cjk_pkg::dec_type [3:0]  dec;
   logic [2:0]                  n;
   logic [2:0]                  len_b;
   logic [3:0]                  pos1;
   logic [3:0]                  pos2;
   logic [2:0]                  cp_valid;
   logic [2:0][20:0]            cps;
   logic                        emit;
   logic [1:0]                  fill;
   logic                        full;
   logic [1:0]                  cnt;

   assign n     = {1'b0, held_count} + 3'd1;
   assign len_b = utf8cjk_pkg::lead_len(in_data.byte_value);

   // held bytes first, then the new byte
   always_comb begin
      buf_b = '0;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < held_count) begin
            buf_b[i] = held[i];
         end
      end
      buf_b[held_count] = in_data.byte_value;
   end

   // decode at every start position
   always_comb begin
      win   = '0;
      avail = '0;
      for (int p = 0; p < 4; p++) begin
         for (int j = 0; j < 4; j++) begin
            if (p + j < 4) begin
               win[p][j] = buf_b[p + j];
            end
         end
         if (3'(p) < n) begin
            avail[p] = n - 3'(p);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < 4; p++) begin
         dec[p] = utf8cjk_pkg::decode_one(win[p], avail[p]);
      end
   end

   // chain the sequence starts
   assign pos1 = {1'b0, dec[0].used};
   assign pos2 = pos1 + {1'b0, dec[pos1[1:0]].used};

   assign cp_valid[0] = 1'b1;
   assign cp_valid[1] = pos1 < {1'b0, n};
   assign cp_valid[2] = cp_valid[1] && (pos2 < {1'b0, n});
   assign cps[0]      = dec[0].cp;
   assign cps[1]      = dec[pos1[1:0]].cp;
   assign cps[2]      = dec[pos2[1:0]].cp;

   assign emit = in_data.string_last ||
                 (sequence_length == 3'd0 && len_b <= 3'd1) ||
                 (sequence_length != 3'd0 && n >= sequence_length);

   // expand code points into results, keep the first three
   always_comb begin
      res  = '0;
      fill = '0;
      full = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (cp_valid[k]) begin
            if (enable && utf8cjk_pkg::is_ideo(cps[k])) begin
               for (int m = 0; m < 3; m++) begin
                  if (!full) begin
                     res[fill].code_point   = (m == 1) ? cps[k] : utf8cjk_pkg::SPACE;
                     res[fill].align_change = (m != 0);
                     if (fill == 2'd2) begin
                        full = 1'b1;
                     end else begin
                        fill = fill + 2'd1;
                     end
                  end
               end
            end else if (!full) begin
               res[fill].code_point   = cps[k];
               res[fill].align_change = 1'b0;
               if (fill == 2'd2) begin
                  full = 1'b1;
               end else begin
                  fill = fill + 2'd1;
               end
            end
         end
      end
      cnt = full ? 2'd3 : fill;
      res[cnt - 2'd1].run_last   = 1'b1;
      res[cnt - 2'd1].string_end = in_data.string_last;
   end

   always_comb begin
      upd = '0;
      if (emit) begin
         upd.res_count = cnt;
      end else if (sequence_length == 3'd0) begin
         upd.held_we         = 1'b1;
         upd.held_idx        = 2'd0;
         upd.held_count      = 2'd1;
         upd.sequence_length = len_b;
      end else begin
         upd.held_we         = 1'b1;
         upd.held_idx        = held_count;
         upd.held_count      = held_count + 2'd1;
         upd.sequence_length = sequence_length;
      end
   end

endmodule

FILE: rtl/utf8cjk_rsp_queue.sv
module utf8cjk_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [1:0]                    load_count,
   input  utf8cjk_pkg::rsp_type [2:0]    load_data,
   output utf8cjk_pkg::q_status_type     status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output utf8cjk_pkg::rsp_type          rsp_data
);

   utf8cjk_pkg::rsp_type [2:0] res_ff;
   utf8cjk_pkg::rsp_type [2:0] res_in;
   logic [1:0]                 rem_ff;
   logic [1:0]                 rem_in;
   logic                       pop;

   assign rsp_valid       = (rem_ff != 2'd0);
   assign rsp_data        = res_ff[0];
   assign pop             = rsp_valid && rsp_ready;
   assign status.empty    = (rem_ff == 2'd0);
   assign status.last_pop = (rem_ff == 2'd1) && rsp_ready;

   // load the whole run, or shift down one per taken result
   always_comb begin
      res_in = res_ff;
      rem_in = rem_ff;
      if (load) begin
         res_in = load_data;
         rem_in = load_count;
      end else if (pop) begin
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         rem_in    = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic [20:0] BAD_CHAR   = utf8cjk_pkg::REPLACEMENT;
   localparam logic [20:0] SPACE_CHAR = utf8cjk_pkg::SPACE;
   localparam int IDLE_TAIL_CYCLES     = 12;
   localparam int RESPONSE_HOLD_CYCLES = 60;
   localparam int BYTES_PER_PHASE      = 100;

   // One row of the directed table; code_point and the two flags are only
   // meaningful when typed is set, otherwise the decoder model supplies them.
   typedef struct packed {
      logic [7:0]  byte_value;
      logic        string_last;
      logic        typed;
      logic [20:0] code_point;
      logic        run_last;
      logic        string_end;
   } dir_row_type;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   utf8cjk_pkg::req_type req_data         = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   utf8cjk_pkg::rsp_type rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic                 csr_write_data   = 1'b0;

   // Decoder model state: bytes of the open sequence, how many are held,
   // and the length announced by its lead (0 when nothing is open).
   logic [7:0]  held_seq [3];
   int          held_n      = 0;
   int          seq_len     = 0;
   logic        spacing_on  = 1'b1;

   utf8cjk_pkg::rsp_type byte_chars [$];     // characters caused by one request
   utf8cjk_pkg::rsp_type expected_chars [$]; // characters still owed by the block
   logic [7:0]           string_bytes [$];   // the string being composed
   dir_row_type          dir_table [25];

   int          mismatch_count = 0;
   logic        tx_steady      = 1'b0;
   logic        rx_steady      = 1'b0;
   logic        hold_responses = 1'b0;

   utf8_decode_cjk_spacing_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs on either channel.
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Decoder model
   // ---------------------------------------------------------------------

   // Sequence length announced by a lead byte; 0 for a byte that cannot lead.
   function automatic int utf8_span(input logic [7:0] b);
      if (b[7] == 1'b0) return 1;
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      if (b[7:3] == 5'b11110) return 4;
      return 0;
   endfunction

   // Ideograph ranges as low/high pairs.
   function automatic logic [20:0] cjk_edge(input int k);
      case (k)
         0:  return 21'h004E00;
         1:  return 21'h009FFF;
         2:  return 21'h003400;
         3:  return 21'h004DBF;
         4:  return 21'h020000;
         5:  return 21'h02A6DF;
         6:  return 21'h02A700;
         7:  return 21'h02B73F;
         8:  return 21'h02B740;
         9:  return 21'h02B81F;
         10: return 21'h02B920;
         11: return 21'h02CEAF;
         12: return 21'h00F900;
         13: return 21'h00FAFF;
         14: return 21'h02F800;
         default: return 21'h02FA1F;
      endcase
   endfunction

   function automatic logic is_cjk_ideograph(input logic [20:0] cp);
      int k;
      for (k = 0; k < 8; k++) begin
         if (cp >= cjk_edge(2 * k) && cp <= cjk_edge(2 * k + 1)) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Decode one code point at win[pos] with avail bytes left; continuation
   // bytes give their low six bits whatever their top bits hold.
   function automatic logic [20:0] decode_at(input logic [3:0][7:0] win, input int pos,
                                             input int avail, output int used);
      int          len;
      int          i;
      logic [20:0] cp;
      len  = utf8_span(win[pos]);
      used = 1;
      if (len == 1) return {13'd0, win[pos]};
      if (len == 0 || avail < len) return BAD_CHAR;
      case (len)
         2:       cp = {16'd0, win[pos][4:0]};
         3:       cp = {17'd0, win[pos][3:0]};
         default: cp = {18'd0, win[pos][2:0]};
      endcase
      for (i = 1; i < len; i++) cp = {cp[14:0], win[pos + i][5:0]};
      used = len;
      return cp;
   endfunction

   // Append one character for the current request; drop anything past three.
   task automatic add_char(input logic [20:0] cp, input logic align);
      utf8cjk_pkg::rsp_type c;
      c.code_point   = cp;
      c.align_change = align;
      c.run_last     = 1'b0;
      c.string_end   = 1'b0;
      if (byte_chars.size() < 3) byte_chars.insert(byte_chars.size(), c);
   endtask

   // Advance the model by one accepted request and leave its characters
   // in byte_chars.
   task automatic decode_request(input utf8cjk_pkg::req_type r);
      logic [3:0][7:0]      win;
      logic [20:0]          cps [4];
      utf8cjk_pkg::rsp_type tail_char;
      int                   n;
      int                   ncp;
      int                   pos;
      int                   used;
      int                   i;
      win = '0;
      n   = 0;
      ncp = 0;
      for (i = 0; i < held_n; i++) begin
         win[n] = held_seq[i];
         n++;
      end
      win[n] = r.byte_value;
      n++;

      if (r.string_last) begin
         // End of string: decode everything held from the start; a lead whose
         // sequence got cut short turns into U+FFFD and the rest is re-read.
         pos = 0;
         while (pos < n) begin
            cps[ncp] = decode_at(win, pos, n - pos, used);
            ncp++;
            pos += used;
         end
         held_n  = 0;
         seq_len = 0;
      end else if (seq_len == 0) begin
         if (utf8_span(r.byte_value) <= 1) begin
            cps[ncp] = decode_at(win, 0, 1, used);
            ncp++;
         end else begin
            held_seq[0] = r.byte_value;
            held_n      = 1;
            seq_len     = utf8_span(r.byte_value);
         end
      end else if (n >= seq_len) begin
         cps[ncp] = decode_at(win, 0, n, used);
         ncp++;
         held_n  = 0;
         seq_len = 0;
      end else begin
         if (held_n < 3) held_seq[held_n] = r.byte_value;
         held_n++;
      end

      byte_chars.delete();
      for (i = 0; i < ncp; i++) begin
         if (spacing_on && is_cjk_ideograph(cps[i])) begin
            add_char(SPACE_CHAR, 1'b0);
            add_char(cps[i], 1'b1);
            add_char(SPACE_CHAR, 1'b1);
         end else begin
            add_char(cps[i], 1'b0);
         end
      end
      if (byte_chars.size() > 0) begin
         tail_char            = byte_chars.pop_back();
         tail_char.run_last   = 1'b1;
         tail_char.string_end = r.string_last;
         byte_chars.insert(byte_chars.size(), tail_char);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one byte after a random gap, hold it until accepted, then queue
   // what it should produce (the typed value when the row gives one).
   task automatic push_request(input logic [7:0] b, input logic last, input logic typed,
                               input utf8cjk_pkg::rsp_type want);
      utf8cjk_pkg::req_type r;
      int                   gap;
      int                   i;
      r.byte_value  = b;
      r.string_last = last;
      gap = tx_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      decode_request(r);
      if (typed) begin
         expected_chars.insert(expected_chars.size(), want);
      end else begin
         for (i = 0; i < byte_chars.size(); i++) begin
            expected_chars.insert(expected_chars.size(), byte_chars[i]);
         end
      end
   endtask

   // Drop valid, let every owed character drain, then let the block settle
   // in case a held byte is still in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_spacing(input logic value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      spacing_on = value;
      csr_write_enable <= 1'b0;
   endtask

   function automatic int min_utf8_len(input logic [20:0] cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   // Encode cp in len bytes; now and then scramble the top bits of a
   // continuation byte, which the decoder must ignore.
   task automatic append_utf8(input logic [20:0] cp, input int len);
      logic [7:0] lead;
      logic [7:0] cont;
      int         i;
      case (len)
         1:       lead = {1'b0, cp[6:0]};
         2:       lead = {3'b110, cp[10:6]};
         3:       lead = {4'b1110, cp[15:12]};
         default: lead = {5'b11110, cp[20:18]};
      endcase
      string_bytes.insert(string_bytes.size(), lead);
      for (i = len - 2; i >= 0; i--) begin
         cont = {2'b10, cp[6 * i +: 6]};
         if ($urandom_range(0, 7) == 0) cont[7:6] = 2'($urandom_range(0, 3));
         string_bytes.insert(string_bytes.size(), cont);
      end
   endtask

   // Build one string: mostly well-formed code points of every length with
   // ideographs and range edges weighted in, plus bad leads, overlong forms,
   // cut-short tails and the odd string of pure noise.
   task automatic compose_string();
      int          n_chars;
      int          kind;
      int          len;
      int          k;
      logic [20:0] cp;
      logic [7:0]  b;
      string_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         n_chars = $urandom_range(1, 6);
         repeat (n_chars) begin
            b = 8'($urandom_range(0, 255));
            string_bytes.insert(string_bytes.size(), b);
         end
      end else begin
         n_chars = $urandom_range(1, 8);
         repeat (n_chars) begin
            kind = $urandom_range(0, 9);
            len  = 0;
            cp   = '0;
            case (kind)
               0, 1: cp = 21'($urandom_range(0, 'h7F));
               2:    cp = 21'($urandom_range('h80, 'h7FF));
               3:    cp = 21'($urandom_range('h800, 'hFFFF));
               4, 5: begin
                  k  = $urandom_range(0, 7);
                  cp = 21'($urandom_range(cjk_edge(2 * k), cjk_edge(2 * k + 1)));
               end
               6:    cp = 21'(cjk_edge($urandom_range(0, 15)) + $urandom_range(0, 2) - 1);
               7:    cp = 21'($urandom_range('h10000, 'h1FFFFF));
               8: begin
                  cp  = 21'($urandom_range(0, 'h7FF));
                  len = $urandom_range(min_utf8_len(cp) + 1, 4);
               end
               default: begin
                  b = $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                           : 8'($urandom_range('hF8, 'hFF));
                  string_bytes.insert(string_bytes.size(), b);
               end
            endcase
            if (kind != 9) append_utf8(cp, (len == 0) ? min_utf8_len(cp) : len);
         end
         // Cut the final sequence short so the string ends inside it.
         if ($urandom_range(0, 5) == 0) begin
            cp  = 21'($urandom_range('h80, 'h1FFFFF));
            len = min_utf8_len(cp);
            append_utf8(cp, len);
            repeat ($urandom_range(1, len - 1)) void'(string_bytes.pop_back());
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, one long hold-off on request,
   // and an in-order check of every character.
   // ---------------------------------------------------------------------
   initial begin
      utf8cjk_pkg::rsp_type want;
      int                   gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_responses) begin
            rsp_ready <= 1'b0;
            repeat (RESPONSE_HOLD_CYCLES) @(posedge clock);
            hold_responses = 1'b0;
         end else begin
            if ($urandom_range(0, 39) == 0) rx_steady = ~rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);

         if (expected_chars.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, got %h", $time, rsp_data);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.code_point !== want.code_point) begin
               mismatch_count++;
               $display("%0t: code_point expected %h got %h", $time,
                        want.code_point, rsp_data.code_point);
            end
            if (rsp_data.align_change !== want.align_change) begin
               mismatch_count++;
               $display("%0t: align_change expected %b got %b", $time,
                        want.align_change, rsp_data.align_change);
            end
            if (rsp_data.run_last !== want.run_last) begin
               mismatch_count++;
               $display("%0t: run_last expected %b got %b", $time,
                        want.run_last, rsp_data.run_last);
            end
            if (rsp_data.string_end !== want.string_end) begin
               mismatch_count++;
               $display("%0t: string_end expected %b got %b", $time,
                        want.string_end, rsp_data.string_end);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      utf8cjk_pkg::rsp_type want;
      logic                 phase_spacing;
      int                   phase;
      int                   row;
      int                   i;
      int                   sent;
      logic                 hold_done;
      logic                 pause_done;

      // Directed rows, spacing at its reset value of 1.
      //                  byte   last  typed  code_point    run   end
      dir_table[0]  = {8'h00, 1'b1, 1'b1, 21'h000000, 1'b1, 1'b1}; // NUL as a whole string
      dir_table[1]  = {8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b1, 1'b0}; // top of ASCII
      dir_table[2]  = {8'h80, 1'b0, 1'b1, BAD_CHAR,   1'b1, 1'b0}; // stray continuation
      dir_table[3]  = {8'hFF, 1'b0, 1'b1, BAD_CHAR,   1'b1, 1'b0}; // invalid lead, top
      dir_table[4]  = {8'hF8, 1'b0, 1'b1, BAD_CHAR,   1'b1, 1'b0}; // invalid lead, bottom
      dir_table[5]  = {8'hC3, 1'b1, 1'b1, BAD_CHAR,   1'b1, 1'b1}; // lead on the last byte
      dir_table[6]  = {8'hC3, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};      // two-byte char
      dir_table[7]  = {8'hA9, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};
      dir_table[8]  = {8'hE4, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};      // U+4E00, spaced
      dir_table[9]  = {8'hB8, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};
      dir_table[10] = {8'h80, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};
      dir_table[11] = {8'hF0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};      // U+20000 ends a string
      dir_table[12] = {8'hA0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};
      dir_table[13] = {8'h80, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};
      dir_table[14] = {8'h80, 1'b1, 1'b0, 21'h0, 1'b0, 1'b0};
      dir_table[15] = {8'hE4, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};      // string ends mid-sequence
      dir_table[16] = {8'h41, 1'b1, 1'b0, 21'h0, 1'b0, 1'b0};
      dir_table[17] = {8'hF7, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};      // largest value, 0x1FFFFF,
      dir_table[18] = {8'hBF, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};      // with one continuation
      dir_table[19] = {8'hFF, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};      // carrying bad top bits
      dir_table[20] = {8'hBF, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};
      dir_table[21] = {8'hC0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};      // overlong NUL
      dir_table[22] = {8'h80, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};
      dir_table[23] = {8'hF0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0};      // two cut leads at the end
      dir_table[24] = {8'hE4, 1'b1, 1'b0, 21'h0, 1'b0, 1'b0};

      held_seq[0] = '0;
      held_seq[1] = '0;
      held_seq[2] = '0;

      // Hold reset, then release it once for the whole run.
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table.
      for (row = 0; row < 25; row++) begin
         want.code_point   = dir_table[row].code_point;
         want.align_change = 1'b0;
         want.run_last     = dir_table[row].run_last;
         want.string_end   = dir_table[row].string_end;
         push_request(dir_table[row].byte_value, dir_table[row].string_last,
                      dir_table[row].typed, want);
      end

      // Random phases: spacing off, on, off, on, then a random setting.
      // The second phase asks the receiver for a long hold-off while requests
      // keep coming; the third pauses the sender until everything drains.
      want       = '0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      for (phase = 0; phase < 5; phase++) begin
         phase_spacing = (phase == 4) ? 1'($urandom_range(0, 1)) : 1'(phase % 2);
         write_spacing(phase_spacing);
         sent = 0;
         while (sent < BYTES_PER_PHASE) begin
            compose_string();
            tx_steady = ($urandom_range(0, 4) == 0);
            for (i = 0; i < string_bytes.size(); i++) begin
               push_request(string_bytes[i], (i == string_bytes.size() - 1), 1'b0, want);
            end
            sent += string_bytes.size();
            if (phase == 1 && !hold_done && sent >= BYTES_PER_PHASE / 2) begin
               hold_responses = 1'b1;
               hold_done      = 1'b1;
            end
            if (phase == 2 && !pause_done && sent >= BYTES_PER_PHASE / 2) begin
               wait_idle();
               pause_done = 1'b1;
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/utf8cjk_pkg.sv
rtl/utf8cjk_decode.sv
rtl/utf8cjk_rsp_queue.sv
rtl/utf8_decode_cjk_spacing_top.sv
bench/tb_top.sv
